// ===== hw/rtl/ebi_pkg.sv =====
// ----------------------------------------------------------------------------
// ebi_pkg: shared types and constants
// Widths, rounding constants and register indexes for the eighth-pel
// bilinear interpolator.
// ----------------------------------------------------------------------------
package ebi_pkg;

    localparam int NUM_LANES = 8;
    localparam int PIX_W     = 8;
    localparam int FRAC_W    = 3;
    localparam int WEIGHT_W  = FRAC_W + 1;
    // horizontal value: 8*a + fx*(b-a), at most 2040
    localparam int HORIZ_W   = 11;
    // vertical sum before shift: at most 8*2040 + 32
    localparam int VERT_W    = 15;
    localparam int RND_SHIFT = 6;
    localparam int CFG_W     = FRAC_W;

    localparam logic [WEIGHT_W-1:0] FRAC_ONE  = WEIGHT_W'(8);
    localparam logic [VERT_W-1:0]   VERT_RND  = VERT_W'(32);

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [FRAC_W-1:0]  frac_t;
    typedef logic [HORIZ_W-1:0] horiz_t;
    typedef logic [CFG_W-1:0]   cfg_data_t;

    typedef enum logic [0:0] {
        CFG_FRAC_X = 1'b0,
        CFG_FRAC_Y = 1'b1
    } cfg_index_t;

    typedef struct packed {
        frac_t frac_x;
        frac_t frac_y;
    } frac_cfg_t;

endpackage

// ===== hw/rtl/ebi_lane.sv =====
// ----------------------------------------------------------------------------
// ebi_lane: one output column
// Horizontal filter on entry, holds current and previous row values,
// vertical filter with rounding on the held pair.
// ----------------------------------------------------------------------------
module ebi_lane (
    input  logic              clk,
    input  logic              load,
    input  ebi_pkg::pix_t     pix_a,
    input  ebi_pkg::pix_t     pix_b,
    input  ebi_pkg::frac_cfg_t frac,
    output ebi_pkg::pix_t     result
);
    import ebi_pkg::*;

    horiz_t                 cur_reg;
    horiz_t                 prev_reg;
    horiz_t                 cur_next;
    logic [WEIGHT_W-1:0]    wx_b;
    logic [WEIGHT_W-1:0]    wx_a;
    logic [WEIGHT_W-1:0]    wy_b;
    logic [WEIGHT_W-1:0]    wy_a;
    logic [HORIZ_W:0]       h_sum;
    logic [VERT_W-1:0]      v_sum;

    assign wx_b = {1'b0, frac.frac_x};
    assign wx_a = FRAC_ONE - wx_b;
    assign wy_b = {1'b0, frac.frac_y};
    assign wy_a = FRAC_ONE - wy_b;

    assign h_sum    = (HORIZ_W+1)'(wx_a * pix_a) + (HORIZ_W+1)'(wx_b * pix_b);
    assign cur_next = h_sum[HORIZ_W-1:0];

    // previous row takes the old current row on every transfer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= cur_next;
        end
    end

    assign v_sum  = VERT_W'(wy_a * prev_reg) + VERT_W'(wy_b * cur_reg) + VERT_RND;
    assign result = v_sum[RND_SHIFT +: PIX_W];

endmodule

// ===== hw/rtl/eighth_pel_bilinear_interp.sv =====
// ----------------------------------------------------------------------------
// eighth_pel_bilinear_interp: eighth-pel bilinear interpolation, 8 wide
// Eight lanes filter one 9-pixel source row each cycle unless stalled; an output
// register gathers the eight lane results into one 8-pixel result row.
//
//   channel | direction | payload           | handshake
//   --------+-----------+-------------------+-------------------
//   input   | in        | pix0..8, first_row| in_valid / in_stall
//   output  | out       | out0..7           | out_valid / out_stall
//   config  | in        | cfg_index, data   | cfg_we
//
// One row per cycle while the output is not stalled; a row goes through a lane
// register and then the output register, which offers its result.
// Reset clears the row-present flag, the lane and output valids and both
// fractions. A stall on the output holds the output register; the lane stage
// holds and the input stalls only while the lane stage has a result and the
// output register is full and stalled.
// ----------------------------------------------------------------------------
module eighth_pel_bilinear_interp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ebi_pkg::pix_t        pix0,
    input  ebi_pkg::pix_t        pix1,
    input  ebi_pkg::pix_t        pix2,
    input  ebi_pkg::pix_t        pix3,
    input  ebi_pkg::pix_t        pix4,
    input  ebi_pkg::pix_t        pix5,
    input  ebi_pkg::pix_t        pix6,
    input  ebi_pkg::pix_t        pix7,
    input  ebi_pkg::pix_t        pix8,
    input  logic                 first_row,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ebi_pkg::pix_t        out0,
    output ebi_pkg::pix_t        out1,
    output ebi_pkg::pix_t        out2,
    output ebi_pkg::pix_t        out3,
    output ebi_pkg::pix_t        out4,
    output ebi_pkg::pix_t        out5,
    output ebi_pkg::pix_t        out6,
    output ebi_pkg::pix_t        out7,
    input  logic                 cfg_we,
    input  ebi_pkg::cfg_index_t  cfg_index,
    input  ebi_pkg::cfg_data_t   cfg_data
);
    import ebi_pkg::*;

    frac_cfg_t  frac_reg;
    logic       have_prev_reg;
    logic       lane_valid_reg;
    logic       lane_emit_reg;
    logic       out_valid_reg;
    pix_t       out_pix_reg [NUM_LANES];

    pix_t       pix_row   [NUM_LANES+1];
    pix_t       lane_res  [NUM_LANES];
    logic       in_xfer;
    logic       out_free;
    logic       lane_move;
    logic       out_load;

    assign pix_row[0] = pix0;
    assign pix_row[1] = pix1;
    assign pix_row[2] = pix2;
    assign pix_row[3] = pix3;
    assign pix_row[4] = pix4;
    assign pix_row[5] = pix5;
    assign pix_row[6] = pix6;
    assign pix_row[7] = pix7;
    assign pix_row[8] = pix8;

    assign out_free  = !out_valid_reg || !out_stall;
    // a row with no result leaves the lane stage at once
    assign lane_move = lane_valid_reg && (!lane_emit_reg || out_free);
    assign out_load  = lane_valid_reg && lane_emit_reg && out_free;
    assign in_stall  = lane_valid_reg && !lane_move;
    assign in_xfer   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAC_X: frac_reg.frac_x <= cfg_data;
                CFG_FRAC_Y: frac_reg.frac_y <= cfg_data;
                default:    frac_reg        <= frac_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg  <= 1'b0;
            lane_valid_reg <= 1'b0;
            lane_emit_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                have_prev_reg  <= 1'b1;
                lane_valid_reg <= 1'b1;
                lane_emit_reg  <= !first_row && have_prev_reg;
            end
            else if (lane_move)
            begin
                lane_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        ebi_lane u_lane (
            .clk    (clk),
            .load   (in_xfer),
            .pix_a  (pix_row[i]),
            .pix_b  (pix_row[i+1]),
            .frac   (frac_reg),
            .result (lane_res[i])
        );

        // merge the lane results into the output row
        always_ff @(posedge clk)
        begin
            if (out_load)
            begin
                out_pix_reg[i] <= lane_res[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out0 = out_pix_reg[0];
    assign out1 = out_pix_reg[1];
    assign out2 = out_pix_reg[2];
    assign out3 = out_pix_reg[3];
    assign out4 = out_pix_reg[4];
    assign out5 = out_pix_reg[5];
    assign out6 = out_pix_reg[6];
    assign out7 = out_pix_reg[7];

endmodule
